### rtl/assert_macros.svh
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define HLP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define HLP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hlp_pkg.sv
`timescale 1ns / 1ps

package hlp_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int LAYER_BITS     = 16;
   localparam int STEP_BITS      = 17;
   localparam int SCALE_LOG      = 10;

   // tie-break nudges on q, r, s
   localparam int NUDGE_Q = 1;
   localparam int NUDGE_R = 1;
   localparam int NUDGE_S = -2;

   localparam int LANE_Q = 0;
   localparam int LANE_R = 1;
   localparam int LANE_S = 2;
   localparam int LANES  = 3;

endpackage

### rtl/hex_line_point_core.sv
`timescale 1ns / 1ps

// Path: input register, delta, clamp and product stages, divider stages, output register.
// Throughput: one item per cycle unless stalled; the divider is one quotient bit per stage.
// A stall on the result side holds the whole pipeline, nothing lost or repeated.
// Reset (synchronous, active high) clears all valid bits; no clearing pass.
module hex_line_point_core #(
   parameter int COORD_BITS = hlp_pkg::COORD_BITS_DEF,
   localparam int IN_W  = ((4 * COORD_BITS + hlp_pkg::LAYER_BITS + hlp_pkg::STEP_BITS + 7)
                           / 8) * 8,
   localparam int OUT_W = ((3 * COORD_BITS + hlp_pkg::LAYER_BITS + 2 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // start_q, start_r, end_q, end_r, layer_id, step_index
   input  logic [IN_W-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // cell_q, cell_r, cell_layer, line_steps, past_end
   output logic [OUT_W-1:0] rsp_tdata
);
   import hlp_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int NB   = C + 1;
   localparam int QB   = NB + 1;
   localparam int DB   = C + 2;
   localparam int TB   = DB + NB + 1;
   localparam int NUMB = TB + SCALE_LOG + 1;
   localparam int XB   = NUMB + 2;
   localparam int DVB  = NB + SCALE_LOG + 1;
   localparam int CW   = C + 4;
   localparam int WW   = (NB > STEP_BITS) ? NB : STEP_BITS;
   localparam int RAW_IN  = 4 * C + LAYER_BITS + STEP_BITS;

   logic en;

   // stage 1: input register
   logic                    v1_ff;
   logic signed [C-1:0]     aq1_ff, ar1_ff, bq1_ff, br1_ff;
   logic [LAYER_BITS-1:0]   lay1_ff;
   logic [STEP_BITS-1:0]    st1_ff;

   // stage 2: deltas and distance
   logic                    v2_ff;
   logic signed [DB-1:0]    dq2_ff, dr2_ff, ds2_ff;
   logic signed [DB-1:0]    dq2_in, dr2_in, ds2_in;
   logic [NB-1:0]           n2_ff, n2_in;
   logic [NB-1:0]           adq, adr, ads;
   logic signed [C-1:0]     aq2_ff, ar2_ff;
   logic [LAYER_BITS-1:0]   lay2_ff;
   logic [STEP_BITS-1:0]    st2_ff;

   // stage 3: clamp step
   logic                    v3_ff;
   logic signed [DB-1:0]    dq3_ff, dr3_ff, ds3_ff;
   logic [NB-1:0]           n3_ff, i3_ff, i3_in;
   logic                    past3_ff, past3_in;
   logic [WW-1:0]           st_w, n_w;
   logic signed [C-1:0]     aq3_ff, ar3_ff;
   logic [LAYER_BITS-1:0]   lay3_ff;

   // stage 4: products
   logic                    v4_ff;
   logic signed [TB-1:0]    t4_ff [LANES];
   logic signed [TB-1:0]    t4_in [LANES];
   logic [NB-1:0]           n4_ff;
   logic                    past4_ff;
   logic signed [C-1:0]     aq4_ff, ar4_ff;
   logic [LAYER_BITS-1:0]   lay4_ff;

   // divider pipeline, index 0 is the dividend stage
   logic                    dv_v_ff    [QB+1];
   logic [XB-1:0]           dv_rem_ff  [QB+1][LANES];
   logic [XB-1:0]           dv_rem_in  [QB+1][LANES];
   logic [QB-1:0]           dv_quo_ff  [QB+1][LANES];
   logic [QB-1:0]           dv_quo_in  [QB+1][LANES];
   logic                    dv_neg_ff  [QB+1][LANES];
   logic                    dv_neg_in  [LANES];
   logic [DVB-1:0]          dv_div_ff  [QB+1];
   logic [NB-1:0]           dv_n_ff    [QB+1];
   logic                    dv_past_ff [QB+1];
   logic signed [C-1:0]     dv_aq_ff   [QB+1];
   logic signed [C-1:0]     dv_ar_ff   [QB+1];
   logic [LAYER_BITS-1:0]   dv_lay_ff  [QB+1];

   // output register
   logic                    ov_ff;
   logic signed [C-1:0]     cq_ff, cr_ff, cq_in, cr_in;
   logic [LAYER_BITS-1:0]   olay_ff;
   logic [NB-1:0]           on_ff;
   logic                    opast_ff;

   assign en         = !ov_ff || rsp_tready;
   assign req_tready = en;

   // stage 2 logic
   always_comb begin
      dq2_in = DB'(bq1_ff) - DB'(aq1_ff);
      dr2_in = DB'(br1_ff) - DB'(ar1_ff);
      ds2_in = -(dq2_in + dr2_in);
      adq    = dq2_in[DB-1] ? NB'(-dq2_in) : NB'(dq2_in);
      adr    = dr2_in[DB-1] ? NB'(-dr2_in) : NB'(dr2_in);
      ads    = ds2_in[DB-1] ? NB'(-ds2_in) : NB'(ds2_in);
      n2_in  = adq;
      if (adr > n2_in) begin
         n2_in = adr;
      end
      if (ads > n2_in) begin
         n2_in = ads;
      end
   end

   // stage 3 logic
   always_comb begin
      st_w     = WW'(st2_ff);
      n_w      = WW'(n2_ff);
      past3_in = st_w > n_w;
      i3_in    = past3_in ? n2_ff : NB'(st_w);
   end

   // stage 4 logic
   always_comb begin
      t4_in[LANE_Q] = TB'(dq3_ff) * TB'($signed({1'b0, i3_ff}));
      t4_in[LANE_R] = TB'(dr3_ff) * TB'($signed({1'b0, i3_ff}));
      t4_in[LANE_S] = TB'(ds3_ff) * TB'($signed({1'b0, i3_ff}));
   end

   // dividend: 2*|1024*t + nudge| + 1024*n, divisor 2048*n
   always_comb begin
      logic signed [NUMB-1:0] num;
      logic [NUMB-1:0]        mag;
      for (int l = 0; l < LANES; l++) begin
         num = (NUMB'(t4_ff[l]) <<< SCALE_LOG);
         if (l == LANE_Q) begin
            num = num + NUMB'(NUDGE_Q);
         end else if (l == LANE_R) begin
            num = num + NUMB'(NUDGE_R);
         end else begin
            num = num + NUMB'(NUDGE_S);
         end
         dv_neg_in[l] = num[NUMB-1];
         mag = num[NUMB-1] ? NUMB'(-num) : NUMB'(num);
         dv_rem_in[0][l] = (XB'(mag) << 1) + (XB'(n4_ff) << SCALE_LOG);
         dv_quo_in[0][l] = '0;
      end
      for (int j = 1; j <= QB; j++) begin
         for (int l = 0; l < LANES; l++) begin
            logic [XB-1:0] sub;
            sub = XB'(dv_div_ff[j-1]) << (QB - j);
            dv_quo_in[j][l] = dv_quo_ff[j-1][l];
            if (dv_rem_ff[j-1][l] >= sub) begin
               dv_rem_in[j][l]          = dv_rem_ff[j-1][l] - sub;
               dv_quo_in[j][l][QB - j]  = 1'b1;
            end else begin
               dv_rem_in[j][l] = dv_rem_ff[j-1][l];
            end
         end
      end
   end

   // rounding and rebuild of the largest-error component
   always_comb begin
      logic signed [CW-1:0] c [LANES];
      logic [XB-1:0]        e [LANES];
      logic [XB-1:0]        half;
      logic signed [CW-1:0] base [LANES];
      base[LANE_Q] = CW'(dv_aq_ff[QB]);
      base[LANE_R] = CW'(dv_ar_ff[QB]);
      base[LANE_S] = -CW'(dv_aq_ff[QB]) - CW'(dv_ar_ff[QB]);
      half = XB'(dv_n_ff[QB]) << SCALE_LOG;
      for (int l = 0; l < LANES; l++) begin
         if (dv_neg_ff[QB][l]) begin
            c[l] = base[l] - CW'(dv_quo_ff[QB][l]);
         end else begin
            c[l] = base[l] + CW'(dv_quo_ff[QB][l]);
         end
         e[l] = (dv_rem_ff[QB][l] > half) ? dv_rem_ff[QB][l] - half
                                          : half - dv_rem_ff[QB][l];
      end
      if (e[LANE_Q] > e[LANE_R] && e[LANE_Q] > e[LANE_S]) begin
         c[LANE_Q] = -c[LANE_R] - c[LANE_S];
      end else if (e[LANE_R] > e[LANE_S]) begin
         c[LANE_R] = -c[LANE_Q] - c[LANE_S];
      end
      if (dv_n_ff[QB] == '0) begin
         cq_in = dv_aq_ff[QB];
         cr_in = dv_ar_ff[QB];
      end else begin
         cq_in = C'(c[LANE_Q]);
         cr_in = C'(c[LANE_R]);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         ov_ff <= 1'b0;
         for (int j = 0; j <= QB; j++) begin
            dv_v_ff[j] <= 1'b0;
         end
      end else if (en) begin
         v1_ff      <= req_tvalid;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         dv_v_ff[0] <= v4_ff;
         for (int j = 1; j <= QB; j++) begin
            dv_v_ff[j] <= dv_v_ff[j-1];
         end
         ov_ff <= dv_v_ff[QB];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         aq1_ff  <= req_tdata[C-1:0];
         ar1_ff  <= req_tdata[2*C-1:C];
         bq1_ff  <= req_tdata[3*C-1:2*C];
         br1_ff  <= req_tdata[4*C-1:3*C];
         lay1_ff <= req_tdata[4*C+LAYER_BITS-1:4*C];
         st1_ff  <= req_tdata[RAW_IN-1:4*C+LAYER_BITS];

         dq2_ff  <= dq2_in;
         dr2_ff  <= dr2_in;
         ds2_ff  <= ds2_in;
         n2_ff   <= n2_in;
         aq2_ff  <= aq1_ff;
         ar2_ff  <= ar1_ff;
         lay2_ff <= lay1_ff;
         st2_ff  <= st1_ff;

         dq3_ff   <= dq2_ff;
         dr3_ff   <= dr2_ff;
         ds3_ff   <= ds2_ff;
         n3_ff    <= n2_ff;
         i3_ff    <= i3_in;
         past3_ff <= past3_in;
         aq3_ff   <= aq2_ff;
         ar3_ff   <= ar2_ff;
         lay3_ff  <= lay2_ff;

         for (int l = 0; l < LANES; l++) begin
            t4_ff[l] <= t4_in[l];
         end
         n4_ff    <= n3_ff;
         past4_ff <= past3_ff;
         aq4_ff   <= aq3_ff;
         ar4_ff   <= ar3_ff;
         lay4_ff  <= lay3_ff;

         for (int l = 0; l < LANES; l++) begin
            dv_rem_ff[0][l] <= dv_rem_in[0][l];
            dv_quo_ff[0][l] <= dv_quo_in[0][l];
            dv_neg_ff[0][l] <= dv_neg_in[l];
         end
         dv_div_ff[0]  <= DVB'(n4_ff) << (SCALE_LOG + 1);
         dv_n_ff[0]    <= n4_ff;
         dv_past_ff[0] <= past4_ff;
         dv_aq_ff[0]   <= aq4_ff;
         dv_ar_ff[0]   <= ar4_ff;
         dv_lay_ff[0]  <= lay4_ff;
         for (int j = 1; j <= QB; j++) begin
            for (int l = 0; l < LANES; l++) begin
               dv_rem_ff[j][l] <= dv_rem_in[j][l];
               dv_quo_ff[j][l] <= dv_quo_in[j][l];
               dv_neg_ff[j][l] <= dv_neg_ff[j-1][l];
            end
            dv_div_ff[j]  <= dv_div_ff[j-1];
            dv_n_ff[j]    <= dv_n_ff[j-1];
            dv_past_ff[j] <= dv_past_ff[j-1];
            dv_aq_ff[j]   <= dv_aq_ff[j-1];
            dv_ar_ff[j]   <= dv_ar_ff[j-1];
            dv_lay_ff[j]  <= dv_lay_ff[j-1];
         end

         cq_ff    <= cq_in;
         cr_ff    <= cr_in;
         olay_ff  <= dv_lay_ff[QB];
         on_ff    <= dv_n_ff[QB];
         opast_ff <= dv_past_ff[QB];
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = OUT_W'({opast_ff, on_ff, olay_ff, cr_ff, cq_ff});

endmodule

### rtl/hlp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hlp_checker #(
   parameter int COORD_BITS = hlp_pkg::COORD_BITS_DEF,
   localparam int IN_W  = ((4 * COORD_BITS + hlp_pkg::LAYER_BITS + hlp_pkg::STEP_BITS + 7)
                           / 8) * 8,
   localparam int OUT_W = ((3 * COORD_BITS + hlp_pkg::LAYER_BITS + 2 + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [IN_W-1:0]  req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [OUT_W-1:0] rsp_tdata
);
   import hlp_pkg::*;

   `HLP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `HLP_ASSERT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped")
   `HLP_ASSERT(a_stall_data, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "result changed")
   `HLP_ASSERT(a_backpressure, clock, reset, rsp_tvalid && !rsp_tready |-> !req_tready, "input taken while stalled")
   `HLP_ASSERT(a_req_known, clock, reset, req_tvalid && req_tready |-> !$isunknown(req_tdata), "unknown input transfer")

endmodule

bind hex_line_point_core hlp_checker #(.COORD_BITS(COORD_BITS)) u_hlp_checker (.*);
